[rtl/totp_generate_and_check_unit_assert.svh]
// Assertion macros for the TOTP generate and check unit.
// Included by the top level; no other dependencies.
`ifndef TOTP_GENERATE_AND_CHECK_UNIT_ASSERT_SVH
`define TOTP_GENERATE_AND_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TOTP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("TOTP assertion failed");
`define TOTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("TOTP assertion failed");
`else
`define TOTP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TOTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/totp_pkg.sv]
// Shared types, constants and helper functions of the TOTP unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package totp_pkg;

   localparam int unsigned TOTP_KEY_BYTES = 32;
   localparam int unsigned TOTP_MAX_SKEW = 7;
   localparam int unsigned TOTP_KEY_LIMIT = 32;
   localparam int unsigned TOTP_DIV_STEPS = 40;
   localparam int unsigned TOTP_SHA_ROUNDS = 80;
   localparam int unsigned TOTP_WIN_W = 5;

   localparam logic [159:0] SHA1_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   typedef struct packed {
      logic        kind;
      logic [39:0] now_seconds;
      logic [29:0] rx_code;
      logic [3:0]  code_length;
      logic        code_well_formed;
   } totp_req_type;

   typedef struct packed {
      logic [29:0] otp_code;
      logic        code_matches;
      logic        no_secret;
   } totp_rsp_type;

   typedef struct packed {
      logic [255:0] key;
      logic [5:0]   key_length;
      logic [3:0]   code_digits;
      logic [31:0]  step_seconds;
      logic [2:0]   skew_windows;
   } totp_cfg_type;

   typedef enum logic [2:0] {
      CSR_KEY_WORD_0,
      CSR_KEY_WORD_1,
      CSR_KEY_WORD_2,
      CSR_KEY_WORD_3,
      CSR_KEY_LENGTH,
      CSR_CODE_DIGITS,
      CSR_TIME_STEP,
      CSR_SKEW_WINDOWS
   } totp_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_TIME,
      ST_BASE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_MOD_START,
      ST_MOD,
      ST_CHECK,
      ST_OUT
   } totp_state_type;

   typedef enum logic [1:0] {
      BLK_IPAD,
      BLK_COUNTER,
      BLK_OPAD,
      BLK_INNER
   } totp_block_type;

   typedef struct packed {
      logic           capture;
      logic           div_time_start;
      logic           div_mod_start;
      logic           div_step;
      logic           ctr_from_quotient;
      logic           ctr_sub_skew;
      logic           ctr_inc;
      logic           load_block;
      totp_block_type block_sel;
      logic           sha_round;
      logic [6:0]     round_idx;
      logic           sha_finish;
      logic           store_code;
      logic           set_match;
      logic           publish;
   } totp_cmd_type;

   typedef struct packed {
      logic                  key_empty;
      logic                  check_enabled;
      logic                  rem_matches;
      logic [TOTP_WIN_W-1:0] window_count;
   } totp_status_type;

   function automatic logic [3:0] totp_digits_eff(input logic [3:0] digits);
      logic [3:0] d;
      d = digits;
      if (digits == 4'd0) d = 4'd1;
      if (digits > 4'd9) d = 4'd9;
      return d;
   endfunction

   function automatic logic [29:0] totp_pow_ten(input logic [3:0] digits);
      logic [29:0] p;
      case (digits)
         4'd1: p = 30'd10;
         4'd2: p = 30'd100;
         4'd3: p = 30'd1000;
         4'd4: p = 30'd10000;
         4'd5: p = 30'd100000;
         4'd6: p = 30'd1000000;
         4'd7: p = 30'd10000000;
         4'd8: p = 30'd100000000;
         4'd9: p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

[rtl/totp_generate_and_check_unit.sv]
// Top level of the TOTP (HMAC-SHA1) generate and check unit.
// Depends on totp_pkg, totp_ctrl, totp_datapath and the assertion macro header.
//
// Usage: a request on the req_ channel carries a time in seconds and, for a
// validate request, a received code. The block returns one response on the
// rsp_ channel with the current window's code, a match flag and a flag that
// says no key is configured. A channel moves a request at a rising edge where
// its valid is high and its stall is low.
// Configuration registers (key words, key length, digits, time step, skew)
// are written through csr_write_enable, csr_index and csr_write_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Sequence: the time is divided by the time step, then
// each HOTP evaluation runs four SHA-1 blocks, a modulo and a check step.
// A request without a key returns after the divide; a validate request adds
// an evaluation for each of its (2 * skew + 1) windows, fewer on an early
// match. All of this runs on the single SHA-1 round engine and the shared
// shift-subtract divider. One request is in work at a time and the next can
// be taken in the cycle after the response is written. Reset clears the
// control state and loads the register defaults. A finished response waits
// in the output register while the receiver stalls; a new request can be
// taken meanwhile.
`timescale 1ns / 1ps
`include "totp_generate_and_check_unit_assert.svh"
module totp_generate_and_check_unit
   import totp_pkg::*;
#(
   parameter int unsigned KEY_BYTES = TOTP_KEY_BYTES,
   parameter int unsigned MAX_SKEW  = TOTP_MAX_SKEW
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  totp_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output totp_rsp_type rsp_payload,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_write_data
);

   // Configuration registers.
   logic [63:0] key_word_ff [4];
   logic [5:0]  key_length_ff;
   logic [3:0]  code_digits_ff;
   logic [31:0] step_seconds_ff;
   logic [2:0]  skew_windows_ff;

   totp_cfg_type    cfg;
   totp_cmd_type    cmd;
   totp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_word_ff[i] <= '0;
         key_length_ff   <= 6'd0;
         code_digits_ff  <= 4'd6;
         step_seconds_ff <= 32'd30;
         skew_windows_ff <= 3'd1;
      end else if (csr_write_enable) begin
         case (totp_csr_type'(csr_index))
            CSR_KEY_WORD_0:   key_word_ff[0]  <= csr_write_data;
            CSR_KEY_WORD_1:   key_word_ff[1]  <= csr_write_data;
            CSR_KEY_WORD_2:   key_word_ff[2]  <= csr_write_data;
            CSR_KEY_WORD_3:   key_word_ff[3]  <= csr_write_data;
            CSR_KEY_LENGTH:   key_length_ff   <= csr_write_data[5:0];
            CSR_CODE_DIGITS:  code_digits_ff  <= csr_write_data[3:0];
            CSR_TIME_STEP:    step_seconds_ff <= csr_write_data[31:0];
            CSR_SKEW_WINDOWS: skew_windows_ff <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // The key is presented as one 256-bit big-endian string, byte 0 on top.
   always_comb begin
      cfg.key          = {key_word_ff[0], key_word_ff[1], key_word_ff[2], key_word_ff[3]};
      cfg.key_length   = key_length_ff;
      cfg.code_digits  = code_digits_ff;
      cfg.step_seconds = step_seconds_ff;
      cfg.skew_windows = skew_windows_ff;
   end

   totp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   totp_datapath #(
      .KEY_BYTES (KEY_BYTES),
      .MAX_SKEW  (MAX_SKEW)
   ) u_datapath (
      .clock       (clock),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // A taken request keeps the input side closed while it is worked on.
   `TOTP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // Without a key the response carries no code and no match.
   `TOTP_ASSERT_IMPLIES(a_no_key_result, clock, reset, rsp_valid && rsp_payload.no_secret,
      rsp_payload.otp_code == 30'd0 && !rsp_payload.code_matches)
   // A returned code always lies below the power of ten in use.
   `TOTP_ASSERT_IMPLIES(a_code_range, clock, reset, rsp_valid,
      rsp_payload.otp_code < totp_pow_ten(totp_digits_eff(code_digits_ff)))

endmodule

[rtl/totp_ctrl.sv]
// Controller of the TOTP unit: sequences divide, SHA-1 blocks, modulo and window checks.
// Depends on totp_pkg; drives the datapath through totp_cmd_type.
`timescale 1ns / 1ps
module totp_ctrl
   import totp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  totp_status_type status,
   output totp_cmd_type    cmd
);

   totp_state_type        state_ff, state_in;
   logic [6:0]            cnt_ff, cnt_in;
   totp_block_type        blk_ff, blk_in;
   logic                  window_pass_ff, window_pass_in;
   logic [TOTP_WIN_W-1:0] win_left_ff, win_left_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         blk_ff         <= BLK_IPAD;
         window_pass_ff <= 1'b0;
         win_left_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         blk_ff         <= blk_in;
         window_pass_ff <= window_pass_in;
         win_left_ff    <= win_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      blk_in         = blk_ff;
      window_pass_in = window_pass_ff;
      win_left_in    = win_left_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.block_sel  = blk_ff;
      cmd.round_idx  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture        = 1'b1;
               cmd.div_time_start = 1'b1;
               cnt_in             = '0;
               state_in           = ST_DIV_TIME;
            end
         end
         ST_DIV_TIME: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff == 7'(TOTP_DIV_STEPS - 1)) state_in = ST_BASE;
         end
         ST_BASE: begin
            cmd.ctr_from_quotient = 1'b1;
            blk_in                = BLK_IPAD;
            window_pass_in        = 1'b0;
            state_in              = status.key_empty ? ST_OUT : ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_block = 1'b1;
            cnt_in         = '0;
            state_in       = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.sha_round = 1'b1;
            cnt_in        = cnt_ff + 7'd1;
            if (cnt_ff == 7'(TOTP_SHA_ROUNDS - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.sha_finish = 1'b1;
            state_in       = ST_LOAD;
            case (blk_ff)
               BLK_IPAD:    blk_in = BLK_COUNTER;
               BLK_COUNTER: blk_in = BLK_OPAD;
               BLK_OPAD:    blk_in = BLK_INNER;
               default:     state_in = ST_MOD_START;
            endcase
         end
         ST_MOD_START: begin
            cmd.div_mod_start = 1'b1;
            cnt_in            = '0;
            state_in          = ST_MOD;
         end
         ST_MOD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff == 7'(TOTP_DIV_STEPS - 1)) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            blk_in = BLK_IPAD;
            if (!window_pass_ff) begin
               cmd.store_code = 1'b1;
               if (status.check_enabled) begin
                  cmd.ctr_sub_skew = 1'b1;
                  win_left_in      = status.window_count;
                  window_pass_in   = 1'b1;
                  state_in         = ST_LOAD;
               end else begin
                  state_in = ST_OUT;
               end
            end else if (status.rem_matches) begin
               cmd.set_match = 1'b1;
               state_in      = ST_OUT;
            end else if (win_left_ff == TOTP_WIN_W'(1)) begin
               state_in = ST_OUT;
            end else begin
               cmd.ctr_inc = 1'b1;
               win_left_in = win_left_ff - TOTP_WIN_W'(1);
               state_in    = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/totp_datapath.sv]
// Datapath of the TOTP unit: shared shift-subtract divider, SHA-1 round engine, counter.
// Depends on totp_pkg; controlled by totp_ctrl through command and status structs.
`timescale 1ns / 1ps
module totp_datapath
   import totp_pkg::*;
#(
   parameter int unsigned KEY_BYTES = TOTP_KEY_BYTES,
   parameter int unsigned MAX_SKEW  = TOTP_MAX_SKEW
) (
   input  logic            clock,
   input  totp_cfg_type    cfg,
   input  totp_req_type    req_payload,
   input  totp_cmd_type    cmd,
   output totp_status_type status,
   output totp_rsp_type    rsp_payload
);

   localparam int unsigned KEY_CAP = (KEY_BYTES < TOTP_KEY_LIMIT) ? KEY_BYTES : TOTP_KEY_LIMIT;
   localparam logic [3:0]  SKEW_CAP = 4'(MAX_SKEW);

   totp_req_type  req_ff;
   logic [31:0]   rem_ff;
   logic [39:0]   quo_ff;
   logic [31:0]   den_ff;
   logic [63:0]   ctr_ff;
   logic [31:0]   a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]   h_ff [5];
   logic [159:0]  inner_ff;
   logic [31:0]   win_ff [16];
   logic [29:0]   code_ff;
   logic          match_ff;
   totp_rsp_type  rsp_ff;

   logic [5:0]    len_eff;
   logic [3:0]    digits_eff;
   logic [3:0]    skew_ext, skew_eff;
   logic [31:0]   step_eff;
   logic [255:0]  key_masked;
   logic [31:0]   blk [16];
   logic [31:0]   new_w, f_val, k_val, t_val;
   logic [159:0]  mac, mac_sh;
   logic [30:0]   trunc;
   logic [32:0]   rem_sh;
   logic          ge;

   always_comb begin
      len_eff    = (cfg.key_length > 6'(KEY_CAP)) ? 6'(KEY_CAP) : cfg.key_length;
      digits_eff = totp_digits_eff(cfg.code_digits);
      skew_ext   = {1'b0, cfg.skew_windows};
      skew_eff   = (skew_ext > SKEW_CAP) ? SKEW_CAP : skew_ext;
      step_eff   = (cfg.step_seconds == 32'd0) ? 32'd1 : cfg.step_seconds;
   end

   // Key bytes past the length read as zero.
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         key_masked[255-8*i -: 8] = (6'(i) < len_eff) ? cfg.key[255-8*i -: 8] : 8'h00;
      end
   end

   always_comb begin
      for (int j = 0; j < 16; j++) blk[j] = 32'h0;
      case (cmd.block_sel)
         BLK_IPAD: begin
            for (int j = 0; j < 16; j++) blk[j] = 32'h36363636;
            for (int j = 0; j < 8; j++) blk[j] = key_masked[255-32*j -: 32] ^ 32'h36363636;
         end
         BLK_OPAD: begin
            for (int j = 0; j < 16; j++) blk[j] = 32'h5C5C5C5C;
            for (int j = 0; j < 8; j++) blk[j] = key_masked[255-32*j -: 32] ^ 32'h5C5C5C5C;
         end
         BLK_COUNTER: begin
            blk[0]  = ctr_ff[63:32];
            blk[1]  = ctr_ff[31:0];
            blk[2]  = 32'h80000000;
            blk[15] = 32'h00000240;
         end
         default: begin
            for (int j = 0; j < 5; j++) blk[j] = inner_ff[159-32*j -: 32];
            blk[5]  = 32'h80000000;
            blk[15] = 32'h000002A0;
         end
      endcase
   end

   // One SHA-1 round; the message schedule runs in a 16-word sliding window.
   always_comb begin
      if (cmd.round_idx < 7'd16) begin
         new_w = win_ff[0];
      end else begin
         new_w = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
         new_w = {new_w[30:0], new_w[31]};
      end
      if (cmd.round_idx < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = 32'h5A827999;
      end else if (cmd.round_idx < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = 32'h6ED9EBA1;
      end else if (cmd.round_idx < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = 32'h8F1BBCDC;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = 32'hCA62C1D6;
      end
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + new_w;
   end

   // Dynamic truncation of the outer digest.
   always_comb begin
      mac    = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
      mac_sh = mac << {h_ff[4][3:0], 3'b000};
      trunc  = mac_sh[158:128];
      rem_sh = {rem_ff, quo_ff[39]};
      ge     = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_payload;
         code_ff  <= '0;
         match_ff <= 1'b0;
      end
      if (cmd.div_time_start) begin
         quo_ff <= req_payload.now_seconds;
         rem_ff <= '0;
         den_ff <= step_eff;
      end else if (cmd.div_mod_start) begin
         quo_ff <= {9'b0, trunc};
         rem_ff <= '0;
         den_ff <= {2'b00, totp_pow_ten(digits_eff)};
      end else if (cmd.div_step) begin
         rem_ff <= ge ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
         quo_ff <= {quo_ff[38:0], ge};
      end
      if (cmd.ctr_from_quotient) ctr_ff <= {24'b0, quo_ff};
      else if (cmd.ctr_sub_skew) ctr_ff <= ctr_ff - {60'b0, skew_eff};
      else if (cmd.ctr_inc) ctr_ff <= ctr_ff + 64'd1;
      if (cmd.load_block) begin
         for (int j = 0; j < 16; j++) win_ff[j] <= blk[j];
         if (cmd.block_sel == BLK_IPAD || cmd.block_sel == BLK_OPAD) begin
            for (int j = 0; j < 5; j++) h_ff[j] <= SHA1_IV[159-32*j -: 32];
            {a_ff, b_ff, c_ff, d_ff, e_ff} <= SHA1_IV;
         end else begin
            {a_ff, b_ff, c_ff, d_ff, e_ff} <= {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};
         end
         if (cmd.block_sel == BLK_OPAD) inner_ff <= mac;
      end else if (cmd.sha_round) begin
         for (int j = 0; j < 15; j++) win_ff[j] <= win_ff[j+1];
         win_ff[15] <= new_w;
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end else if (cmd.sha_finish) begin
         h_ff[0] <= h_ff[0] + a_ff;
         h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff;
         h_ff[3] <= h_ff[3] + d_ff;
         h_ff[4] <= h_ff[4] + e_ff;
      end
      if (cmd.store_code) code_ff <= rem_ff[29:0];
      if (cmd.set_match) match_ff <= 1'b1;
      if (cmd.publish) begin
         rsp_ff.otp_code     <= code_ff;
         rsp_ff.code_matches <= match_ff;
         rsp_ff.no_secret    <= (cfg.key_length == 6'd0);
      end
   end

   always_comb begin
      status.key_empty     = (len_eff == 6'd0);
      status.check_enabled = req_ff.kind & req_ff.code_well_formed &
                             (req_ff.code_length == digits_eff);
      status.rem_matches   = (rem_ff == {2'b00, req_ff.rx_code});
      status.window_count  = {skew_eff, 1'b1};
   end

   assign rsp_payload = rsp_ff;

endmodule
